FILE: hdl/e2q_pkg.sv
// Shared constants, widths and arctangent table for the Euler-to-quaternion block.
// No dependencies.
package e2q_pkg;
    localparam int ANG_FRAC      = 30;
    localparam int TABLE_LEN     = 32;
    localparam int Z_W           = 34;
    localparam int XY_W          = 34;
    localparam int CS_W          = 32;
    localparam int IN_W          = 16;
    localparam int OUT_W         = 16;
    localparam int DEF_CORDIC_STEPS  = 16;
    localparam int DEF_OUT_FRAC_BITS = 14;

    localparam logic signed [Z_W-1:0]  PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
            18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
            21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
            24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
            27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction
endpackage

FILE: hdl/euler_to_quaternion_top.sv
// Euler angles (ZYX) to unit quaternion, fully pipelined.
// Throughput: one item per cycle; range reduction, the unrolled CORDIC steps, two
// multiply stages and the rounding stage make up the pipeline. busy stays low.
// Reset (synchronous, active low) clears the valid pipeline only.
// Depends on e2q_pkg, e2q_cordic, e2q_mult.
module euler_to_quaternion_top import e2q_pkg::*; #(
    parameter int CORDIC_STEPS  = DEF_CORDIC_STEPS,
    parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [IN_W-1:0]  i_roll_angle,
    input  logic signed [IN_W-1:0]  i_pitch_angle,
    input  logic signed [IN_W-1:0]  i_yaw_angle,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_comp_real,
    output logic signed [OUT_W-1:0] o_comp_x,
    output logic signed [OUT_W-1:0] o_comp_y,
    output logic signed [OUT_W-1:0] o_comp_z
);
    localparam int NS  = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int LAT = NS + 4;

    logic signed [CS_W-1:0] cr, sr, cp, sp, cy, sy;
    logic [LAT-1:0] r_vld, n_vld;

    e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .i_clk(i_clk), .i_angle(i_roll_angle), .o_cos(cr), .o_sin(sr));
    e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk(i_clk), .i_angle(i_pitch_angle), .o_cos(cp), .o_sin(sp));
    e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk(i_clk), .i_angle(i_yaw_angle), .o_cos(cy), .o_sin(sy));

    e2q_mult #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mult (
        .i_clk(i_clk),
        .i_cr(cr), .i_sr(sr), .i_cp(cp), .i_sp(sp), .i_cy(cy), .i_sy(sy),
        .o_comp_real(o_comp_real), .o_comp_x(o_comp_x),
        .o_comp_y(o_comp_y), .o_comp_z(o_comp_z));

    assign n_vld = {r_vld[LAT-2:0], start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign busy    = 1'b0;
    assign o_valid = r_vld[LAT-1];

    a_no_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy asserted");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching item");
endmodule

FILE: hdl/e2q_cordic.sv
// Half-angle range reduction and unrolled rotation CORDIC, one step per stage.
// Depends on e2q_pkg.
module e2q_cordic import e2q_pkg::*; #(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic                   i_clk,
    input  logic signed [IN_W-1:0] i_angle,
    output logic signed [CS_W-1:0] o_cos,
    output logic signed [CS_W-1:0] o_sin
);
    localparam int NS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    logic signed [XY_W-1:0] r_x   [NS+1];
    logic signed [XY_W-1:0] r_y   [NS+1];
    logic signed [Z_W-1:0]  r_z   [NS+1];
    logic                   r_neg [NS+1];

    logic signed [Z_W-1:0] n_z;
    logic                  n_neg;
    logic signed [Z_W-1:0] z_in;

    always_comb begin
        z_in = Z_W'(i_angle) <<< 17;
        n_z = z_in;
        n_neg = 1'b0;
        if (z_in > HALF_PI_Q30) begin
            n_z = z_in - PI_Q30;
            n_neg = 1'b1;
        end else if (z_in < -HALF_PI_Q30) begin
            n_z = z_in + PI_Q30;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= GAIN_Q30;
        r_y[0]   <= '0;
        r_z[0]   <= n_z;
        r_neg[0] <= n_neg;
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic signed [XY_W-1:0] dx, dy;
        logic signed [Z_W-1:0]  at;
        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;
        assign at = $signed({{(Z_W-32){1'b0}}, atan_q30(k)});
        always_ff @(posedge i_clk) begin
            if (!r_z[k][Z_W-1]) begin
                r_x[k+1] <= r_x[k] - dx;
                r_y[k+1] <= r_y[k] + dy;
                r_z[k+1] <= r_z[k] - at;
            end else begin
                r_x[k+1] <= r_x[k] + dx;
                r_y[k+1] <= r_y[k] - dy;
                r_z[k+1] <= r_z[k] + at;
            end
            r_neg[k+1] <= r_neg[k];
        end
    end

    assign o_cos = r_neg[NS] ? CS_W'(-r_x[NS]) : CS_W'(r_x[NS]);
    assign o_sin = r_neg[NS] ? CS_W'(-r_y[NS]) : CS_W'(r_y[NS]);
endmodule

FILE: hdl/e2q_mult.sv
// Triple-product quaternion assembly, rounding and saturation in three stages.
// Depends on e2q_pkg.
module e2q_mult import e2q_pkg::*; #(
    parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic signed [CS_W-1:0]  i_cr, i_sr, i_cp, i_sp, i_cy, i_sy,
    output logic signed [OUT_W-1:0] o_comp_real,
    output logic signed [OUT_W-1:0] o_comp_x,
    output logic signed [OUT_W-1:0] o_comp_y,
    output logic signed [OUT_W-1:0] o_comp_z
);
    localparam int SW = CS_W + 3;
    localparam int SH = ANG_FRAC - OUT_FRAC_BITS;
    localparam logic signed [SW-1:0] RND = (SW'(1) <<< SH) >>> 1;
    localparam logic signed [SW-1:0] ONE = SW'(1) <<< OUT_FRAC_BITS;

    function automatic logic signed [CS_W-1:0] mq(input logic signed [CS_W-1:0] a,
                                                 input logic signed [CS_W-1:0] b);
        logic signed [2*CS_W-1:0] p;
        p = a * b;
        return p[ANG_FRAC+CS_W-1:ANG_FRAC];
    endfunction

    function automatic logic signed [OUT_W-1:0] fin(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = (v + RND) >>> SH;
        if (t > ONE) t = ONE;
        if (t < -ONE) t = -ONE;
        return t[OUT_W-1:0];
    endfunction

    logic signed [CS_W-1:0] r_crcp, r_srcp, r_crsp, r_srsp, r_cy, r_sy;
    logic signed [CS_W-1:0] r_p [8];

    always_ff @(posedge i_clk) begin
        r_crcp <= mq(i_cr, i_cp);
        r_srcp <= mq(i_sr, i_cp);
        r_crsp <= mq(i_cr, i_sp);
        r_srsp <= mq(i_sr, i_sp);
        r_cy   <= i_cy;
        r_sy   <= i_sy;

        r_p[0] <= mq(r_crcp, r_cy);
        r_p[1] <= mq(r_srsp, r_sy);
        r_p[2] <= mq(r_srcp, r_cy);
        r_p[3] <= mq(r_crsp, r_sy);
        r_p[4] <= mq(r_crsp, r_cy);
        r_p[5] <= mq(r_srcp, r_sy);
        r_p[6] <= mq(r_crcp, r_sy);
        r_p[7] <= mq(r_srsp, r_cy);

        o_comp_real <= fin(SW'(r_p[0]) + SW'(r_p[1]));
        o_comp_x    <= fin(SW'(r_p[2]) - SW'(r_p[3]));
        o_comp_y    <= fin(SW'(r_p[4]) + SW'(r_p[5]));
        o_comp_z    <= fin(SW'(r_p[6]) - SW'(r_p[7]));
    end
endmodule
